>>> sv/hpid_pkg.sv
// ----------------------------------------------------------------------------
// hpid_pkg
// Types, constants and the microprogram of the heater PID controller.
// ----------------------------------------------------------------------------
package hpid_pkg;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  // multiplier operand selects
  typedef enum logic [2:0] {
    A_ERR,
    A_INTEG,
    A_DIFF,
    A_PROD,
    A_DFILT
  } a_sel_t;

  typedef enum logic [2:0] {
    B_PGAIN,
    B_IGAIN,
    B_ALPHA,
    B_DGAIN,
    B_BETA
  } b_sel_t;

  // jump conditions
  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_OUT_BUSY
  } cond_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SETPOINT,
    REG_P_GAIN,
    REG_I_GAIN,
    REG_D_GAIN,
    REG_INTEGRAL_LIMIT
  } reg_idx_t;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   ld_in;
    logic   ld_p;
    logic   ld_i;
    logic   ld_acc;
    logic   ld_d;
    logic   ld_out;
    cond_t  cond;
    step_t  target;
  } ctrl_t;

  typedef struct packed {
    logic in_req;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic [15:0] setpoint;
    logic [23:0] p_gain;
    logic [23:0] i_gain;
    logic [23:0] d_gain;
    logic [30:0] integral_limit;
  } cfg_t;

  localparam int CFG_W = 31;

  localparam logic signed [24:0] ALPHA_Q16 = 25'sd3277;
  localparam logic signed [24:0] BETA_Q16  = 25'sd62259;
  localparam logic signed [56:0] I_ONE_Q24 = 57'sd16777216;
  localparam logic [16:0]        I_ONE_Q16 = 17'h10000;

  // microprogram: one control word per step
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c.a_sel  = A_ERR;
    c.b_sel  = B_PGAIN;
    c.ld_in  = 1'b0;
    c.ld_p   = 1'b0;
    c.ld_i   = 1'b0;
    c.ld_acc = 1'b0;
    c.ld_d   = 1'b0;
    c.ld_out = 1'b0;
    c.cond   = COND_NEVER;
    c.target = '0;
    case (s)
      3'd0: begin
        c.ld_in  = 1'b1;
        c.cond   = COND_NO_INPUT;
        c.target = 3'd0;
      end
      3'd1: begin
        c.a_sel = A_ERR;
        c.b_sel = B_PGAIN;
      end
      3'd2: begin
        c.ld_p  = 1'b1;
        c.a_sel = A_INTEG;
        c.b_sel = B_IGAIN;
      end
      3'd3: begin
        c.ld_i  = 1'b1;
        c.a_sel = A_DIFF;
        c.b_sel = B_ALPHA;
      end
      3'd4: begin
        c.a_sel = A_PROD;
        c.b_sel = B_DGAIN;
      end
      3'd5: begin
        c.ld_acc = 1'b1;
        c.a_sel  = A_DFILT;
        c.b_sel  = B_BETA;
      end
      3'd6: begin
        c.ld_d = 1'b1;
      end
      3'd7: begin
        c.ld_out = 1'b1;
        c.cond   = COND_OUT_BUSY;
        c.target = 3'd7;
      end
      default: begin
        c.cond = COND_NEVER;
      end
    endcase
    return c;
  endfunction

endpackage

>>> sv/hpid_useq.sv
// ----------------------------------------------------------------------------
// hpid_useq
// Step counter and microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module hpid_useq (
  input  logic               clk,
  input  logic               rst_n,
  input  hpid_pkg::status_t  stat,
  output hpid_pkg::ctrl_t    ctrl
);

  hpid_pkg::step_t step_r;
  hpid_pkg::step_t step_nxt;
  logic            take;

  assign ctrl = hpid_pkg::ucode(step_r);

  always_comb begin
    case (ctrl.cond)
      hpid_pkg::COND_NO_INPUT: take = !stat.in_req;
      hpid_pkg::COND_OUT_BUSY: take = stat.out_busy;
      default:                 take = 1'b0;
    endcase
  end

  assign step_nxt = take ? ctrl.target : step_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> sv/hpid_datapath.sv
// ----------------------------------------------------------------------------
// hpid_datapath
// Shared multiplier, PID state and output register, driven by control words.
// ----------------------------------------------------------------------------
module hpid_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  hpid_pkg::cfg_t      cfg,
  input  hpid_pkg::ctrl_t     ctrl,
  output hpid_pkg::status_t   stat,
  input  logic                in_valid,
  input  logic signed [15:0]  in_temperature,
  input  logic                out_stall,
  output logic                out_valid,
  output logic signed [31:0]  out_drive,
  output logic signed [31:0]  out_p_term,
  output logic [30:0]         out_integral_sum,
  output logic signed [31:0]  out_d_term,
  output logic                out_low_clipped
);

  localparam logic signed [57:0] SAT_MAX   = 58'sd2147483647;
  localparam logic signed [57:0] SAT_MIN   = -58'sd2147483648;
  localparam logic signed [33:0] DRIVE_MAX = 34'sd65536;
  localparam logic signed [33:0] DRIVE_MIN = -34'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [57:0] v);
    if (v > SAT_MAX) begin
      return SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      return SAT_MIN[31:0];
    end
    return v[31:0];
  endfunction

  logic signed [15:0] temp_r,  temp_nxt;
  logic signed [16:0] err_r,   err_nxt;
  logic signed [16:0] diff_r,  diff_nxt;
  logic signed [56:0] prod_r,  prod_nxt;
  logic signed [31:0] p_r,     p_nxt;
  logic [16:0]        ival_r,  ival_nxt;
  logic signed [56:0] acc_r,   acc_nxt;
  logic [30:0]        integ_r, integ_nxt;
  logic signed [31:0] dfilt_r, dfilt_nxt;
  logic signed [15:0] prev_r,  prev_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] drive_r, drive_nxt;
  logic               clip_r,  clip_nxt;

  logic               in_take;
  logic               out_busy;
  logic               out_load;
  logic signed [32:0] integ_sum;
  logic [30:0]        integ_c;
  logic signed [31:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] p_shift;
  logic signed [57:0] d_sum;
  logic signed [33:0] drv_sum;

  assign in_take  = ctrl.ld_in & in_valid;
  assign out_busy = out_valid_r & out_stall;
  assign out_load = ctrl.ld_out & !out_busy;

  assign stat.in_req   = in_valid;
  assign stat.out_busy = out_busy;

  // integral clamped to [0, 2^31-1]
  assign integ_sum = $signed({2'b00, integ_r}) + $signed({{16{err_r[16]}}, err_r});
  always_comb begin
    if (integ_sum[32]) begin
      integ_c = '0;
    end else if (integ_sum[31]) begin
      integ_c = '1;
    end else begin
      integ_c = integ_sum[30:0];
    end
  end

  always_comb begin
    case (ctrl.a_sel)
      hpid_pkg::A_ERR:   mul_a = $signed({{15{err_r[16]}}, err_r});
      hpid_pkg::A_INTEG: mul_a = $signed({1'b0, integ_c});
      hpid_pkg::A_DIFF:  mul_a = $signed({{15{diff_r[16]}}, diff_r});
      hpid_pkg::A_PROD:  mul_a = prod_r[31:0];
      hpid_pkg::A_DFILT: mul_a = dfilt_r;
      default:           mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.b_sel)
      hpid_pkg::B_PGAIN: mul_b = $signed({1'b0, cfg.p_gain});
      hpid_pkg::B_IGAIN: mul_b = $signed({1'b0, cfg.i_gain});
      hpid_pkg::B_ALPHA: mul_b = hpid_pkg::ALPHA_Q16;
      hpid_pkg::B_DGAIN: mul_b = $signed({1'b0, cfg.d_gain});
      hpid_pkg::B_BETA:  mul_b = hpid_pkg::BETA_Q16;
      default:           mul_b = '0;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  assign p_shift = $signed({prod_r[56], prod_r}) >>> 8;
  // alpha term plus 256 * beta * d
  assign d_sum   = $signed({acc_r[56], acc_r})
                 + $signed({prod_r[48], prod_r[48:0], 8'b0});
  assign drv_sum = $signed({{2{p_r[31]}}, p_r}) + $signed({17'b0, ival_r})
                 - $signed({{2{dfilt_r[31]}}, dfilt_r});

  always_comb begin
    temp_nxt      = temp_r;
    err_nxt       = err_r;
    diff_nxt      = diff_r;
    p_nxt         = p_r;
    ival_nxt      = ival_r;
    acc_nxt       = acc_r;
    integ_nxt     = integ_r;
    dfilt_nxt     = dfilt_r;
    prev_nxt      = prev_r;
    drive_nxt     = drive_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_busy;
    if (in_take) begin
      temp_nxt = in_temperature;
      err_nxt  = $signed({cfg.setpoint[15], cfg.setpoint})
               - $signed({in_temperature[15], in_temperature});
      diff_nxt = $signed({in_temperature[15], in_temperature})
               - $signed({prev_r[15], prev_r});
    end
    if (ctrl.ld_p) begin
      p_nxt = sat32(p_shift);
    end
    if (ctrl.ld_i) begin
      if (prod_r > hpid_pkg::I_ONE_Q24) begin
        ival_nxt  = hpid_pkg::I_ONE_Q16;
        integ_nxt = cfg.integral_limit;
      end else begin
        ival_nxt  = prod_r[24:8];
        integ_nxt = integ_c;
      end
    end
    if (ctrl.ld_acc) begin
      acc_nxt = prod_r;
    end
    if (ctrl.ld_d) begin
      dfilt_nxt = sat32(d_sum >>> 24);
      prev_nxt  = temp_r;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      if (drv_sum > DRIVE_MAX) begin
        drive_nxt = DRIVE_MAX[31:0];
        clip_nxt  = 1'b0;
      end else if (drv_sum < DRIVE_MIN) begin
        drive_nxt = DRIVE_MIN[31:0];
        clip_nxt  = 1'b1;
      end else begin
        drive_nxt = drv_sum[31:0];
        clip_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      dfilt_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      integ_r     <= integ_nxt;
      dfilt_r     <= dfilt_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    temp_r  <= temp_nxt;
    err_r   <= err_nxt;
    diff_r  <= diff_nxt;
    prod_r  <= prod_nxt;
    p_r     <= p_nxt;
    ival_r  <= ival_nxt;
    acc_r   <= acc_nxt;
    drive_r <= drive_nxt;
    clip_r  <= clip_nxt;
  end

  // output register, loaded only at the output step
  logic signed [31:0] out_p_r,     out_p_nxt;
  logic [30:0]        out_integ_r, out_integ_nxt;
  logic signed [31:0] out_d_r,     out_d_nxt;

  assign out_p_nxt     = out_load ? p_r       : out_p_r;
  assign out_integ_nxt = out_load ? integ_r   : out_integ_r;
  assign out_d_nxt     = out_load ? dfilt_r   : out_d_r;

  always_ff @(posedge clk) begin
    out_p_r     <= out_p_nxt;
    out_integ_r <= out_integ_nxt;
    out_d_r     <= out_d_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_drive        = drive_r;
  assign out_p_term       = out_p_r;
  assign out_integral_sum = out_integ_r;
  assign out_d_term       = out_d_r;
  assign out_low_clipped  = clip_r;

endmodule

>>> sv/heater_pid_controller.sv
// ----------------------------------------------------------------------------
// heater_pid_controller
// PID heater controller with integral anti-windup, microcoded datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one temperature request
//   (in_temperature, 1/16 degC). Result channel: out_valid / out_stall carry
//   drive, p_term, integral_sum, d_term and low_clipped.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 setpoint, 1 p_gain, 2 i_gain, 3 d_gain, 4 integral_limit);
//   other indexes are ignored. Write only while idle.
//   Requests are processed one at a time by the 8-step microprogram that
//   runs all products through one shared 32x25 multiplier.
//   out_valid is registered and is set when step 7 loads the result.
//   The request is accepted at step 0; in_stall stays high for steps 1-7.
//   A finished result waits in the output register; if out_stall holds it,
//   the last step repeats and no new request is taken until it drains.
//   Reset (rst_n low, synchronous) clears the configuration, the integral,
//   the filtered derivative, the previous temperature and the output valid.
// ----------------------------------------------------------------------------
module heater_pid_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [hpid_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [15:0]          in_temperature,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_drive,
  output logic signed [31:0]          out_p_term,
  output logic [30:0]                 out_integral_sum,
  output logic signed [31:0]          out_d_term,
  output logic                        out_low_clipped
);

  hpid_pkg::cfg_t    cfg_r;
  hpid_pkg::cfg_t    cfg_nxt;
  hpid_pkg::ctrl_t   ctrl;
  hpid_pkg::status_t stat;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        hpid_pkg::REG_SETPOINT:       cfg_nxt.setpoint       = cfg_wdata[15:0];
        hpid_pkg::REG_P_GAIN:         cfg_nxt.p_gain         = cfg_wdata[23:0];
        hpid_pkg::REG_I_GAIN:         cfg_nxt.i_gain         = cfg_wdata[23:0];
        hpid_pkg::REG_D_GAIN:         cfg_nxt.d_gain         = cfg_wdata[23:0];
        hpid_pkg::REG_INTEGRAL_LIMIT: cfg_nxt.integral_limit = cfg_wdata;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = !ctrl.ld_in;

  hpid_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  hpid_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_temperature   (in_temperature),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_drive        (out_drive),
    .out_p_term       (out_p_term),
    .out_integral_sum (out_integral_sum),
    .out_d_term       (out_d_term),
    .out_low_clipped  (out_low_clipped)
  );

`ifndef SYNTHESIS
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted on consecutive cycles");

  a_valid_from_ustep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctrl.ld_out))
    else $error("result appeared outside the output step");

  a_drive_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive <= 32'sd65536))
    else $error("drive above full scale");

  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_low_clipped) |-> (out_drive == 32'sh80000000))
    else $error("low clip flagged without saturated drive");
`endif

endmodule

>>> dv/heater_pid_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heater_pid_controller_tb
// Self-checking bench for the heater PID controller. A table of directed
// requests (reset state, gain and setpoint extremes, integral clamp, reload
// and saturation, low-end clipping) is followed by random gain settings with
// temperature walks around the setpoint mixed with full-range noise. Every
// result is compared field by field against a literal or in-bench fixed-point
// model, with random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module heater_pid_controller_tb;

  localparam int     IDLE_PCT    = 11;
  localparam int     HOLD_CYCLES = 300;
  localparam int     QUIET       = 12;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     N_PHASES    = 12;
  localparam int     PHASE_ITEMS = 112;
  localparam int     HOLD_PHASE  = 2;
  localparam int     PAUSE_PHASE = 4;
  localparam int     CALM_PHASE  = 6;

  localparam longint WT_NEW      = 3277;
  localparam longint WT_OLD      = 62259;
  localparam longint Q16_UNITY   = 65536;
  localparam longint Q24_UNITY   = 64'sd16777216;
  localparam longint S32_MAX     = 64'sd2147483647;
  localparam longint S32_MIN     = -64'sd2147483648;

  localparam logic [2:0] REG_UNUSED = 3'd5;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] p_term;
    logic [30:0]        integral_sum;
    logic signed [31:0] d_term;
    logic               low_clipped;
  } pid_result_t;

  typedef enum logic {ROW_CFG, ROW_TEMP} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [2:0]         idx;
    logic [30:0]        value;
    logic signed [15:0] temp;
    logic               lit;
    pid_result_t        want;
  } dir_row_t;

  localparam pid_result_t NO_RES = '0;
  localparam int N_DIR = 28;

  localparam dir_row_t DIRECTED [0:N_DIR-1] = '{
    '{ROW_TEMP, 3'd0, 31'd0, 16'sh8000, 1'b1,
      '{32'sh0, 32'sh0, 31'd32768, 32'sh0, 1'b0}},
    '{ROW_TEMP, 3'd0, 31'd0, 16'sh7FFF, 1'b1,
      '{32'sh0, 32'sh0, 31'd1, 32'sh0, 1'b0}},
    '{ROW_TEMP, 3'd0, 31'd0, 16'sh7FFF, 1'b1,
      '{32'sh0, 32'sh0, 31'd0, 32'sh0, 1'b0}},
    '{ROW_CFG, hpid_pkg::REG_SETPOINT, 31'h7FFF, 16'sh0, 1'b0, NO_RES},
    '{ROW_CFG, hpid_pkg::REG_P_GAIN, 31'hFFFFFF, 16'sh0, 1'b0, NO_RES},
    '{ROW_TEMP, 3'd0, 31'd0, 16'sh8000, 1'b1,
      '{32'sh00010000, 32'sh7FFFFFFF, 31'd65535, 32'sh0, 1'b0}},
    '{ROW_CFG, hpid_pkg::REG_SETPOINT, 31'h8000, 16'sh0, 1'b0, NO_RES},
    '{ROW_CFG, hpid_pkg::REG_D_GAIN, 31'hFFFFFF, 16'sh0, 1'b0, NO_RES},
    '{ROW_CFG, REG_UNUSED, 31'h7FFFFFFF, 16'sh0, 1'b0, NO_RES},
    '{ROW_TEMP, 3'd0, 31'd0, 16'sh8000, 1'b1,
      '{32'sh0, 32'sh0, 31'd65535, 32'sh0, 1'b0}},
    '{ROW_TEMP, 3'd0, 31'd0, 16'sh7FFF, 1'b0, NO_RES},
    '{ROW_TEMP, 3'd0, 31'd0, 16'sh8000, 1'b0, NO_RES},
    '{ROW_TEMP, 3'd0, 31'd0, 16'sh0000, 1'b0, NO_RES},
    '{ROW_CFG, hpid_pkg::REG_SETPOINT, 31'h7FFF, 16'sh0, 1'b0, NO_RES},
    '{ROW_CFG, hpid_pkg::REG_P_GAIN, 31'h0, 16'sh0, 1'b0, NO_RES},
    '{ROW_CFG, hpid_pkg::REG_I_GAIN, 31'hFFFFFF, 16'sh0, 1'b0, NO_RES},
    '{ROW_CFG, hpid_pkg::REG_D_GAIN, 31'h0, 16'sh0, 1'b0, NO_RES},
    '{ROW_CFG, hpid_pkg::REG_INTEGRAL_LIMIT, 31'h7FFFFFFF, 16'sh0, 1'b0, NO_RES},
    '{ROW_TEMP, 3'd0, 31'd0, 16'sh7FFD, 1'b0, NO_RES},
    '{ROW_TEMP, 3'd0, 31'd0, 16'sh7FFF, 1'b0, NO_RES},
    '{ROW_CFG, hpid_pkg::REG_I_GAIN, 31'h0, 16'sh0, 1'b0, NO_RES},
    '{ROW_TEMP, 3'd0, 31'd0, 16'sh8000, 1'b0, NO_RES},
    '{ROW_CFG, hpid_pkg::REG_SETPOINT, 31'h0, 16'sh0, 1'b0, NO_RES},
    '{ROW_CFG, hpid_pkg::REG_I_GAIN, 31'h100000, 16'sh0, 1'b0, NO_RES},
    '{ROW_CFG, hpid_pkg::REG_INTEGRAL_LIMIT, 31'h0, 16'sh0, 1'b0, NO_RES},
    '{ROW_TEMP, 3'd0, 31'd0, 16'sh7FFF, 1'b0, NO_RES},
    '{ROW_TEMP, 3'd0, 31'd0, 16'shFFF0, 1'b0, NO_RES},
    '{ROW_TEMP, 3'd0, 31'd0, 16'shFFFF, 1'b0, NO_RES}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [30:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_temperature = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_drive;
  logic signed [31:0] out_p_term;
  logic [30:0]        out_integral_sum;
  logic signed [31:0] out_d_term;
  logic               out_low_clipped;

  heater_pid_controller uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_temperature   (in_temperature),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drive        (out_drive),
    .out_p_term       (out_p_term),
    .out_integral_sum (out_integral_sum),
    .out_d_term       (out_d_term),
    .out_low_clipped  (out_low_clipped)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // controller model: configuration and loop state
  logic signed [15:0] sp = '0;
  logic [23:0]        kp = '0;
  logic [23:0]        ki = '0;
  logic [23:0]        kd = '0;
  logic [30:0]        integ_limit = '0;
  logic [30:0]        integ_acc = '0;
  logic signed [31:0] d_filt = '0;
  logic signed [15:0] prev_temp = '0;

  pid_result_t pid_results_due[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  requests_sent = 0;
  int  cycles = 0;
  int  hold_asked = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  int  walk = 0;
  bit  calm = 1'b0;
  bit  busy = 1'b0;

  function automatic longint clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic void apply_cfg(input logic [2:0] idx, input logic [30:0] val);
    case (idx)
      hpid_pkg::REG_SETPOINT:       sp = val[15:0];
      hpid_pkg::REG_P_GAIN:         kp = val[23:0];
      hpid_pkg::REG_I_GAIN:         ki = val[23:0];
      hpid_pkg::REG_D_GAIN:         kd = val[23:0];
      hpid_pkg::REG_INTEGRAL_LIMIT: integ_limit = val;
      default: ;
    endcase
  endfunction

  function automatic pid_result_t pid_update(input logic signed [15:0] t);
    longint err, p, integ, iprod, ival, diff, acc, d, sum;
    pid_result_t r;
    err = longint'(sp) - longint'(t);
    p = clamp32((longint'(kp) * err) >>> 8);

    integ = longint'(integ_acc) + err;
    if (integ < 0) integ = 0;
    if (integ > S32_MAX) integ = S32_MAX;
    iprod = integ * longint'(ki);
    if (iprod > Q24_UNITY) begin
      ival = Q16_UNITY;
      integ = longint'(integ_limit);
    end else begin
      ival = iprod >>> 8;
    end
    integ_acc = integ[30:0];

    diff = longint'(t) - longint'(prev_temp);
    acc = WT_NEW * (longint'(kd) * diff) + WT_OLD * (longint'(d_filt) * 256);
    d = clamp32(acc >>> 24);
    d_filt = d[31:0];
    prev_temp = t;

    sum = p + ival - d;
    if (sum > Q16_UNITY) sum = Q16_UNITY;
    r.low_clipped = 1'b0;
    if (sum < S32_MIN) begin
      sum = S32_MIN;
      r.low_clipped = 1'b1;
    end
    r.drive = sum[31:0];
    r.p_term = p[31:0];
    r.integral_sum = integ_acc;
    r.d_term = d[31:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] e,
                                      input logic [31:0] a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0d got %0d", results_seen, name,
                 $signed(e), $signed(a));
    end
  endfunction

  // result side: checking, random stall and the long hold-off
  always @(posedge clk) begin : result_check
    pid_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pid_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result, drive %0d", out_drive);
      end else begin
        want = pid_results_due.pop_front();
        check_field("drive", want.drive, out_drive);
        check_field("p_term", want.p_term, out_p_term);
        check_field("integral_sum", {1'b0, want.integral_sum}, {1'b0, out_integral_sum});
        check_field("d_term", want.d_term, out_d_term);
        check_field("low_clipped", 32'(want.low_clipped), 32'(out_low_clipped));
      end
      results_seen++;
    end
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we <= 1'b1;
    apply_cfg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_temp(input logic signed [15:0] t, input logic lit,
                           input pid_result_t lit_want);
    pid_result_t got;
    cfg_we <= 1'b0;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_temperature <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    got = pid_update(t);
    pid_results_due.push_back(lit ? lit_want : got);
    requests_sent++;
    busy = 1'b1;
  endtask

  task automatic wait_results();
    do @(posedge clk); while (pid_results_due.size() != 0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait_results();
    repeat (QUIET) @(posedge clk);
    busy = 1'b0;
  endtask

  function automatic logic [23:0] rand_gain();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2:       return 24'($urandom());
      default: return 24'($urandom_range(1, 1 << 20));
    endcase
  endfunction

  task automatic new_gains(input int ph);
    logic [31:0] v;
    logic [15:0] s;
    logic [23:0] g_p, g_i, g_d;
    logic [30:0] lim;
    if (ph == 0) begin
      s = 16'($urandom());
      g_p = '1;
      g_i = '1;
      g_d = '1;
      lim = '1;
    end else if (ph == 1) begin
      s = '0;
      g_p = '0;
      g_i = '0;
      g_d = '0;
      lim = '0;
    end else begin
      s = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4000));
      g_p = rand_gain();
      g_i = rand_gain();
      g_d = rand_gain();
      if (g_i != 0 && $urandom_range(0, 2) != 0) begin
        lim = 31'((32'd1 << 24) / g_i);
      end else begin
        case ($urandom_range(0, 2))
          0:       lim = '0;
          1:       lim = '1;
          default: lim = 31'($urandom());
        endcase
      end
    end
    v = $urandom();
    v[15:0] = s;
    write_reg(hpid_pkg::REG_SETPOINT, v[30:0]);
    v = $urandom();
    v[23:0] = g_p;
    write_reg(hpid_pkg::REG_P_GAIN, v[30:0]);
    v = $urandom();
    v[23:0] = g_i;
    write_reg(hpid_pkg::REG_I_GAIN, v[30:0]);
    v = $urandom();
    v[23:0] = g_d;
    write_reg(hpid_pkg::REG_D_GAIN, v[30:0]);
    write_reg(hpid_pkg::REG_INTEGRAL_LIMIT, lim);
    if ($urandom_range(0, 3) == 0)
      write_reg(3'(REG_UNUSED + $urandom_range(0, 2)), 31'($urandom()));
    walk = int'($signed(s));
  endtask

  // mostly a slow drift around the setpoint, some full-range noise
  function automatic logic signed [15:0] pick_temp();
    int step;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      step = int'($urandom_range(0, 40)) - 20;
      step += (walk < int'(sp)) ? 4 : -4;
      walk += step;
      if (walk > 32767) walk = 32767;
      if (walk < -32768) walk = -32768;
      return 16'(walk);
    end else if (roll < 90) begin
      return 16'($urandom());
    end
    return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
  endfunction

  initial begin : stimulus
    dir_row_t row;
    int i;
    int ph;
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIR; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_CFG) begin
        if (busy) settle();
        write_reg(row.idx, row.value);
      end else begin
        send_temp(row.temp, row.lit, row.want);
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      if (busy) settle();
      new_gains(ph);
      calm = (ph == CALM_PHASE);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == HOLD_PHASE && k == 30) hold_asked++;
        if (ph == PAUSE_PHASE && k == 60) begin
          in_valid <= 1'b0;
          wait_results();
        end
        send_temp(pick_temp(), 1'b0, NO_RES);
      end
      calm = 1'b0;
    end
    settle();

    $display("%0d temperature requests over %0d gain settings plus directed cases,",
             requests_sent, N_PHASES);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
